// ===== hw/rtl/sswr_pkg.sv =====
// Shared types and constants for the signed scalar wNAF recoder.
package sswr_pkg;

    localparam int LIMB_W    = 64;
    localparam int NUM_LIMBS = 4;
    localparam int SCALAR_W  = LIMB_W * NUM_LIMBS;

    // Positions examined per scan cycle when looking for the next digit.
    localparam int SCAN_SPAN = 8;
    localparam int SPAN_IDX_W = $clog2(SCAN_SPAN);

    // Curve group order, limb 0 in the low slot.
    localparam logic [NUM_LIMBS-1:0][LIMB_W-1:0] GROUP_ORDER = {
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFE,
        64'hBAAE_DCE6_AF48_A03B,
        64'hBFD2_5E8C_D036_4141
    };

    // Control outcome of one scan step.
    typedef struct packed {
        logic found;
        logic carry_next;
        logic done;
    } step_ctl_t;

endpackage

// ===== hw/rtl/signed_scalar_wnaf_recoder.sv =====
// Top level: signed 256-bit scalar to width-WINDOW NAF digit stream.
//
// One scalar is taken per transaction; s_ready is high only while the block
// is idle. A negative scalar (bit 255 set) first runs limb by limb through a
// single 64-bit subtract unit to form group order minus scalar, then the
// check state tests that the magnitude fits in DIGIT_POSITIONS bits. Each
// scan step then either takes one nonzero digit, advancing at least WINDOW
// positions, or skips a span of eight digit-free positions; a scalar has at
// most ceil(DIGIT_POSITIONS/WINDOW) digits, 26 with the defaults. Digits are
// held in a small buffer because a final carry voids them; after the prepare
// state primes the registered buffer read, results leave at one per cycle
// while the sink keeps up. An error or zero magnitude gives a single result
// after the scan or check. Sink stalls during output delay the next transaction.
module signed_scalar_wnaf_recoder #(
    parameter int DIGIT_POSITIONS = 129,
    parameter int WINDOW          = 5
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [63:0]                          s_scalar_limb0,
    input  logic [63:0]                          s_scalar_limb1,
    input  logic [63:0]                          s_scalar_limb2,
    input  logic [63:0]                          s_scalar_limb3,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [$clog2(DIGIT_POSITIONS+1)-1:0] m_digit_position,
    output logic signed [WINDOW-1:0]             m_digit_value,
    output logic                                 m_digit_present,
    output logic [$clog2(DIGIT_POSITIONS+1)-1:0] m_digit_length,
    output logic                                 m_range_error,
    output logic                                 m_last_result
);

    localparam int POS_W      = $clog2(DIGIT_POSITIONS + 1);
    localparam int MAX_DIGITS = (DIGIT_POSITIONS + WINDOW - 1) / WINDOW;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int ENTRY_W    = POS_W + WINDOW;
    localparam int LIMB_IDX_W = $clog2(sswr_pkg::NUM_LIMBS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_NEG    = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_SINGLE = 3'd4;
    localparam logic [2:0] ST_PREP   = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    logic [sswr_pkg::NUM_LIMBS-1:0][sswr_pkg::LIMB_W-1:0] mag_reg;
    logic [sswr_pkg::SCALAR_W-1:0] mag_flat;
    logic [LIMB_IDX_W-1:0]         limb_idx_reg;
    logic                          borrow_reg;
    logic                          neg_reg;
    logic [DIGIT_POSITIONS-1:0]    sh_reg;
    logic [POS_W-1:0]              bit_reg;
    logic                          carry_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              idx_reg;
    logic                          single_err_reg;

    logic [sswr_pkg::LIMB_W-1:0] sub_diff;
    logic                        sub_borrow;
    logic                        over_range;

    logic [DIGIT_POSITIONS-1:0]  step_sh;
    logic [POS_W-1:0]            step_bit;
    logic [POS_W-1:0]            step_pos;
    logic signed [WINDOW-1:0]    step_digit;
    sswr_pkg::step_ctl_t         step_ctl;
    logic [CNT_W-1:0]            cnt_after;

    logic                buf_we;
    logic [ADDR_W-1:0]   buf_raddr;
    logic [ENTRY_W-1:0]  buf_rdata;
    logic [POS_W-1:0]    rd_pos;
    logic [WINDOW-1:0]   rd_digit;
    logic                slot_free;
    logic                emit_take;
    logic                emit_last;
    logic [CNT_W-1:0]    idx_inc;

    assign mag_flat   = mag_reg;
    assign over_range = |(mag_flat >> DIGIT_POSITIONS);

    sswr_sub_unit u_sub (
        .a          (sswr_pkg::GROUP_ORDER[limb_idx_reg]),
        .b          (mag_reg[limb_idx_reg]),
        .borrow_in  (borrow_reg),
        .diff       (sub_diff),
        .borrow_out (sub_borrow)
    );

    sswr_scan_step #(
        .DIGIT_POSITIONS (DIGIT_POSITIONS),
        .WINDOW          (WINDOW),
        .POS_W           (POS_W)
    ) u_step (
        .sh        (sh_reg),
        .carry     (carry_reg),
        .neg       (neg_reg),
        .bit_pos   (bit_reg),
        .sh_next   (step_sh),
        .bit_next  (step_bit),
        .digit_pos (step_pos),
        .digit     (step_digit),
        .ctl       (step_ctl)
    );

    assign buf_we    = (state_reg == ST_SCAN) && step_ctl.found;
    assign cnt_after = cnt_reg + {{(CNT_W-1){1'b0}}, buf_we};
    assign slot_free = !m_valid_reg || m_ready;
    assign emit_take = (state_reg == ST_EMIT) && slot_free;
    assign idx_inc   = idx_reg + {{(CNT_W-1){1'b0}}, 1'b1};
    assign emit_last = (idx_inc == cnt_reg);
    // Read one entry ahead so a result can leave every cycle while the sink keeps up.
    assign buf_raddr = emit_take ? idx_inc[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign rd_pos    = buf_rdata[ENTRY_W-1:WINDOW];
    assign rd_digit  = buf_rdata[WINDOW-1:0];

    sswr_digit_buf #(
        .DEPTH  (MAX_DIGITS),
        .DATA_W (ENTRY_W)
    ) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata ({step_pos, step_digit}),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_scalar_limb3[63] ? ST_NEG : ST_CHECK;
                end
            end
            ST_NEG: begin
                if (limb_idx_reg == LIMB_IDX_W'(sswr_pkg::NUM_LIMBS - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = over_range ? ST_SINGLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (step_ctl.done) begin
                    if (step_ctl.carry_next || cnt_after == '0) begin
                        state_next = ST_SINGLE;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_SINGLE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PREP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                mag_reg      <= {s_scalar_limb3, s_scalar_limb2,
                                 s_scalar_limb1, s_scalar_limb0};
                neg_reg      <= s_scalar_limb3[63];
                limb_idx_reg <= '0;
                borrow_reg   <= 1'b0;
            end
            ST_NEG: begin
                mag_reg[limb_idx_reg] <= sub_diff;
                borrow_reg            <= sub_borrow;
                limb_idx_reg          <= limb_idx_reg + 1'b1;
            end
            ST_CHECK: begin
                sh_reg         <= mag_flat[DIGIT_POSITIONS-1:0];
                bit_reg        <= '0;
                carry_reg      <= 1'b0;
                cnt_reg        <= '0;
                idx_reg        <= '0;
                single_err_reg <= over_range;
            end
            ST_SCAN: begin
                sh_reg         <= step_sh;
                bit_reg        <= step_bit;
                carry_reg      <= step_ctl.carry_next;
                cnt_reg        <= cnt_after;
                single_err_reg <= step_ctl.carry_next;
            end
            ST_SINGLE: begin
                if (slot_free) begin
                    m_digit_position <= '0;
                    m_digit_value    <= '0;
                    m_digit_present  <= 1'b0;
                    m_digit_length   <= '0;
                    m_range_error    <= single_err_reg;
                    m_last_result    <= 1'b1;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_digit_position <= rd_pos;
                    m_digit_value    <= rd_digit;
                    m_digit_present  <= 1'b1;
                    m_digit_length   <= emit_last ? (rd_pos + 1'b1) : '0;
                    m_range_error    <= 1'b0;
                    m_last_result    <= emit_last;
                    idx_reg          <= idx_inc;
                end
            end
            default: begin
            end
        endcase
    end

    a_err_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_last_result && !m_digit_present)
        else $error("error result carries a digit or is not last");

    a_digit_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_digit_present |-> m_digit_value[0])
        else $error("emitted digit is even");

    a_len_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_result && m_digit_present |->
            m_digit_length == POS_W'(m_digit_position + 1'b1))
        else $error("digit length does not follow last position");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count exceeds buffer depth");

endmodule

// ===== hw/rtl/sswr_sub_unit.sv =====
// 64-bit subtract-with-borrow unit, reused once per limb for negation.
module sswr_sub_unit (
    input  logic [sswr_pkg::LIMB_W-1:0] a,
    input  logic [sswr_pkg::LIMB_W-1:0] b,
    input  logic                        borrow_in,
    output logic [sswr_pkg::LIMB_W-1:0] diff,
    output logic                        borrow_out
);

    logic [sswr_pkg::LIMB_W:0] wide;

    always_comb begin
        wide = {1'b0, a} - {1'b0, b} - {{sswr_pkg::LIMB_W{1'b0}}, borrow_in};
        diff = wide[sswr_pkg::LIMB_W-1:0];
        borrow_out = wide[sswr_pkg::LIMB_W];
    end

endmodule

// ===== hw/rtl/sswr_scan_step.sv =====
// One NAF scan step: find the next digit within a short span and advance.
module sswr_scan_step #(
    parameter int DIGIT_POSITIONS = 129,
    parameter int WINDOW          = 5,
    parameter int POS_W           = 8
) (
    input  logic [DIGIT_POSITIONS-1:0] sh,
    input  logic                       carry,
    input  logic                       neg,
    input  logic [POS_W-1:0]           bit_pos,
    output logic [DIGIT_POSITIONS-1:0] sh_next,
    output logic [POS_W-1:0]           bit_next,
    output logic [POS_W-1:0]           digit_pos,
    output logic signed [WINDOW-1:0]   digit,
    output sswr_pkg::step_ctl_t        ctl
);

    localparam int NXT_W   = $clog2(DIGIT_POSITIONS + sswr_pkg::SCAN_SPAN + WINDOW);
    localparam int SHAMT_W = $clog2(sswr_pkg::SCAN_SPAN + WINDOW);

    logic [sswr_pkg::SCAN_SPAN-1:0]  diff;
    logic [sswr_pkg::SPAN_IDX_W-1:0] k;
    logic [WINDOW-1:0]               window;
    logic [WINDOW:0]                 word;
    logic [WINDOW-1:0]               mag_digit;
    logic [SHAMT_W-1:0]              shamt;
    logic [NXT_W-1:0]                nxt;

    always_comb begin
        // Mark positions in range whose bit differs from the running carry.
        for (int i = 0; i < sswr_pkg::SCAN_SPAN; i++) begin
            diff[i] = (sh[i] ^ carry) &&
                      ((NXT_W'(bit_pos) + NXT_W'(i)) < NXT_W'(DIGIT_POSITIONS));
        end
        k = '0;
        for (int i = sswr_pkg::SCAN_SPAN - 1; i >= 0; i--) begin
            if (diff[i]) begin
                k = sswr_pkg::SPAN_IDX_W'(i);
            end
        end
        ctl.found = |diff;
        window    = sh[k +: WINDOW];
        word      = {1'b0, window} + {{WINDOW{1'b0}}, carry};
        // Digit is the low window bits read as two's complement, negated for a negative scalar.
        mag_digit = word[WINDOW-1:0];
        digit     = neg ? -mag_digit : mag_digit;
        ctl.carry_next = ctl.found ? word[WINDOW-1] : carry;
        shamt = ctl.found ? (SHAMT_W'(k) + SHAMT_W'(WINDOW))
                          : SHAMT_W'(sswr_pkg::SCAN_SPAN);
        sh_next   = sh >> shamt;
        nxt       = NXT_W'(bit_pos) + NXT_W'(shamt);
        ctl.done  = nxt >= NXT_W'(DIGIT_POSITIONS);
        bit_next  = nxt[POS_W-1:0];
        digit_pos = bit_pos + POS_W'(k);
    end

endmodule

// ===== hw/rtl/sswr_digit_buf.sv =====
// Digit buffer: one write port, one registered read port.
module sswr_digit_buf #(
    parameter int DEPTH  = 26,
    parameter int DATA_W = 13
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/signed_scalar_wnaf_recoder_tb.sv =====
// Self-checking testbench for the signed scalar wNAF recoder.
module signed_scalar_wnaf_recoder_tb;

    localparam int SCALAR_W        = sswr_pkg::SCALAR_W;
    localparam int DIGIT_POSITIONS = 129;
    localparam int WINDOW          = 5;
    localparam int POS_W           = $clog2(DIGIT_POSITIONS + 1);
    localparam int RANDOM_SCALARS  = 250;
    localparam int CALM_TAIL       = 40;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;

    localparam logic [SCALAR_W-1:0] ORDER = sswr_pkg::GROUP_ORDER;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [WINDOW-1:0] value;
        logic              present;
        logic [POS_W-1:0]  length;
        logic              range_error;
        logic              last;
    } digit_result_t;

    typedef struct {
        logic [SCALAR_W-1:0] scalar;
        bit                  typed;
        digit_result_t       typed_result;
    } scalar_case_t;

    localparam digit_result_t ZERO_RESULT = '{position: '0, value: '0, present: 1'b0,
                                              length: '0, range_error: 1'b0, last: 1'b1};
    localparam digit_result_t RANGE_ERROR = '{position: '0, value: '0, present: 1'b0,
                                              length: '0, range_error: 1'b1, last: 1'b1};

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [63:0]             s_scalar_limb0 = '0;
    logic [63:0]             s_scalar_limb1 = '0;
    logic [63:0]             s_scalar_limb2 = '0;
    logic [63:0]             s_scalar_limb3 = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [POS_W-1:0]        m_digit_position;
    logic signed [WINDOW-1:0] m_digit_value;
    logic                    m_digit_present;
    logic [POS_W-1:0]        m_digit_length;
    logic                    m_range_error;
    logic                    m_last_result;

    digit_result_t pending_digits[$];
    scalar_case_t  directed_cases[$];
    int            mismatch_count = 0;
    int            stall_cycles = 0;
    bit            calm = 1'b0;

    signed_scalar_wnaf_recoder #(
        .DIGIT_POSITIONS(DIGIT_POSITIONS),
        .WINDOW(WINDOW)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_scalar_limb0(s_scalar_limb0),
        .s_scalar_limb1(s_scalar_limb1),
        .s_scalar_limb2(s_scalar_limb2),
        .s_scalar_limb3(s_scalar_limb3),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_digit_position(m_digit_position),
        .m_digit_value(m_digit_value),
        .m_digit_present(m_digit_present),
        .m_digit_length(m_digit_length),
        .m_range_error(m_range_error),
        .m_last_result(m_last_result)
    );

    always #5 aclk = ~aclk;

    // Recode one scalar and queue the digit results it should produce.
    function automatic void recode_scalar(input logic [SCALAR_W-1:0] scalar);
        logic [SCALAR_W-1:0] mag;
        logic                neg;
        int                  pos_idx;
        int                  carry;
        int                  now;
        int                  word;
        digit_result_t       digits[$];
        digit_result_t       r;
        neg = scalar[SCALAR_W-1];
        mag = neg ? ORDER - scalar : scalar;
        if ((mag >> DIGIT_POSITIONS) != 0) begin
            pending_digits.push_back(RANGE_ERROR);
            return;
        end
        pos_idx = 0;
        carry = 0;
        while (pos_idx < DIGIT_POSITIONS) begin
            if (mag[pos_idx] == carry[0]) begin
                pos_idx++;
            end else begin
                now = (DIGIT_POSITIONS - pos_idx < WINDOW) ? DIGIT_POSITIONS - pos_idx : WINDOW;
                word = int'((mag >> pos_idx) & ((256'd1 << now) - 1)) + carry;
                carry = (word >> (WINDOW - 1)) & 1;
                word -= carry << WINDOW;
                r = '0;
                r.position = POS_W'(pos_idx);
                r.value = WINDOW'(neg ? -word : word);
                r.present = 1'b1;
                digits.push_back(r);
                pos_idx += now;
            end
        end
        if (carry != 0) begin
            pending_digits.push_back(RANGE_ERROR);
        end else if (digits.size() == 0) begin
            pending_digits.push_back(ZERO_RESULT);
        end else begin
            digits[digits.size()-1].length = digits[digits.size()-1].position + 1'b1;
            digits[digits.size()-1].last = 1'b1;
            foreach (digits[i]) pending_digits.push_back(digits[i]);
        end
    endfunction

    function automatic digit_result_t lone_digit(input int pos, input int val);
        digit_result_t r;
        r = '0;
        r.position = POS_W'(pos);
        r.value = WINDOW'(val);
        r.present = 1'b1;
        r.length = POS_W'(pos + 1);
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_case(input logic [SCALAR_W-1:0] scalar, input bit typed,
                                     input digit_result_t typed_result);
        scalar_case_t c;
        c.scalar = scalar;
        c.typed = typed;
        c.typed_result = typed_result;
        directed_cases.push_back(c);
    endfunction

    function automatic logic [SCALAR_W-1:0] random_bits();
        logic [SCALAR_W-1:0] r;
        r = '0;
        for (int i = 0; i < SCALAR_W / 32; i++) r = {r[SCALAR_W-33:0], $urandom};
        return r;
    endfunction

    // Mostly in-range magnitudes of random length and sign, plus noise and edges.
    function automatic logic [SCALAR_W-1:0] random_scalar();
        logic [SCALAR_W-1:0] mag;
        logic                neg;
        int                  len;
        int                  pick;
        pick = $urandom_range(0, 9);
        neg = 1'($urandom_range(0, 1));
        if (pick <= 4) begin
            len = $urandom_range(0, DIGIT_POSITIONS);
            mag = random_bits() & ((256'd1 << len) - 1);
            if ($urandom_range(0, 1) == 1) mag &= random_bits() & random_bits();
        end else if (pick == 5) begin
            mag = 256'($urandom_range(0, 1023));
        end else if (pick <= 7) begin
            return random_bits();
        end else if (pick == 8) begin
            mag = (256'd1 << DIGIT_POSITIONS) - 256'($urandom_range(0, 3))
                  + 256'($urandom_range(0, 1));
        end else begin
            return $urandom_range(0, 1) ? ORDER + 256'($urandom_range(0, 3))
                                        : ORDER - 256'($urandom_range(0, 3));
        end
        return neg ? ORDER - mag : mag;
    endfunction

    // Offer one transaction, optionally after an idle burst, and hold until taken.
    task automatic send_scalar(input logic [SCALAR_W-1:0] scalar, input bit typed,
                               input digit_result_t typed_result);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_scalar_limb0 <= scalar[63:0];
        s_scalar_limb1 <= scalar[127:64];
        s_scalar_limb2 <= scalar[191:128];
        s_scalar_limb3 <= scalar[255:192];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed) pending_digits.push_back(typed_result);
        else recode_scalar(scalar);
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        digit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: result expected none actual position %0d value %0h last %0b",
                         $time, m_digit_position, m_digit_value, m_last_result);
                mismatch_count++;
            end else begin
                want = pending_digits.pop_front();
                compare_field("digit_position", 16'(want.position), 16'(m_digit_position));
                compare_field("digit_value", 16'(want.value),
                              16'($unsigned(m_digit_value)));
                compare_field("digit_present", 16'(want.present), 16'(m_digit_present));
                compare_field("digit_length", 16'(want.length), 16'(m_digit_length));
                compare_field("range_error", 16'(want.range_error), 16'(m_range_error));
                compare_field("last_result", 16'(want.last), 16'(m_last_result));
            end
        end
    end

    // Sink side: random stall bursts, none once the run is calm.
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [SCALAR_W-1:0] every_fifth;
        every_fifth = {64'h0, 64'h0, 64'h2108_4210_8421_0842, 64'h1084_2108_4210_8421};

        add_case(256'd0, 1'b1, ZERO_RESULT);
        add_case(256'd1, 1'b1, lone_digit(0, 1));
        add_case(256'd1 << 128, 1'b1, lone_digit(128, 1));
        add_case(256'd1 << 129, 1'b1, RANGE_ERROR);
        add_case((256'd1 << 129) - 1, 1'b1, RANGE_ERROR);          // carry out of the top
        add_case(ORDER - 1, 1'b1, lone_digit(0, -1));
        add_case(ORDER, 1'b1, ZERO_RESULT);
        add_case(ORDER + 1, 1'b1, RANGE_ERROR);                     // negative above order wraps
        add_case({SCALAR_W{1'b1}}, 1'b1, RANGE_ERROR);
        add_case(256'd1 << 254, 1'b1, RANGE_ERROR);
        add_case(256'd15, 1'b0, '0);
        add_case(256'd17, 1'b0, '0);
        add_case(ORDER - 15, 1'b0, '0);
        add_case(ORDER - (256'd1 << 128), 1'b0, '0);
        add_case(ORDER - ((256'd1 << 129) - 1), 1'b0, '0);
        add_case(every_fifth, 1'b0, '0);                            // densest digit stream
        add_case(ORDER - every_fifth, 1'b0, '0);
        add_case({64'h0, 64'h1, {2{64'h5555_5555_5555_5555}}}, 1'b0, '0);
        add_case({64'h0, 64'h0, {2{64'hAAAA_AAAA_AAAA_AAAA}}}, 1'b0, '0);
        add_case((256'd1 << 128) | (256'd1 << 124) | 256'd7, 1'b0, '0);
        add_case({192'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0);
        add_case(ORDER - {192'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cases[i]) begin
            send_scalar(directed_cases[i].scalar, directed_cases[i].typed,
                        directed_cases[i].typed_result);
        end
        for (int i = 0; i < RANDOM_SCALARS; i++) begin
            if (i == RANDOM_SCALARS - CALM_TAIL) calm = 1'b1;
            send_scalar(random_scalar(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sswr_pkg.sv
hw/rtl/sswr_sub_unit.sv
hw/rtl/sswr_scan_step.sv
hw/rtl/sswr_digit_buf.sv
hw/rtl/signed_scalar_wnaf_recoder.sv
tb/signed_scalar_wnaf_recoder_tb.sv
